### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

### design/gspid_pkg.sv
// ----------------------------------------------------------------------------
// gspid_pkg
// Types, constants and register map of the gain-scheduled PID drive block.
// ----------------------------------------------------------------------------
package gspid_pkg;

    localparam int LEVEL_MIN    = 1;
    localparam int LEVEL_MEDIUM = 2;
    localparam int LEVEL_LARGE  = 3;
    localparam int LEVEL_MAX    = 4;
    localparam int LEVEL_URGENT = 5;

    localparam int ONE_Q12        = 4096;
    localparam int GAIN_SET_COUNT = 6;
    localparam int LIMIT_W        = 14;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd3686;

    typedef enum logic [2:0] {
        REG_GAINS_MIN    = 3'd0,
        REG_GAINS_MEDIUM = 3'd1,
        REG_GAINS_LARGE  = 3'd2,
        REG_GAINS_MAX    = 3'd3,
        REG_GAINS_URGENT = 3'd4,
        REG_GAINS_DEFAULT = 3'd5,
        REG_INTEGRAL_GAIN = 3'd6,
        REG_OUTPUT_LIMIT  = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        SEL_MIN     = 3'd0,
        SEL_MEDIUM  = 3'd1,
        SEL_LARGE   = 3'd2,
        SEL_MAX     = 3'd3,
        SEL_URGENT  = 3'd4,
        SEL_DEFAULT = 3'd5
    } gain_sel_t;

    typedef struct packed {
        logic signed [7:0] error_now;
        logic signed [7:0] error_before;
    } sample_t;

    typedef struct packed {
        logic signed [14:0]       pid_value;
        logic [LIMIT_W-1:0]       left_speed;
        logic [LIMIT_W-1:0]       right_speed;
        logic                     left_reverse;
        logic                     right_reverse;
    } result_t;

    typedef struct packed {
        logic [GAIN_SET_COUNT-1:0][31:0] gains;
        logic signed [15:0]              ki;
        logic [LIMIT_W-1:0]              limit;
    } cfg_t;

    typedef struct packed {
        logic signed [7:0] err;
        logic signed [8:0] diff;
        gain_sel_t         sel;
        logic              use_ki;
    } stage_t;

endpackage

### design/gain_scheduled_pid_differential_drive.sv
// ----------------------------------------------------------------------------
// gain_scheduled_pid_differential_drive
// Gain-scheduled PID steering controller with differential motor outputs.
//
//   channel   direction  handshake                  beat
//   sample    in         sample_valid/sample_stall  error_now, error_before
//   result    out        result_valid/result_stall  pid, speeds, reverse flags
//   config    in         APB psel/penable/pready    one 32-bit register
//
// One sample per cycle unless stalled; result_valid sets as result_reg loads.
// The integrator updates at the accept edge; gains are muxed and the three
// products, sum and clamps run between the stage register and result register.
// Reset clears valid flags and the integrator and loads the register defaults.
// A stalled result holds; the stage register still fills, then sample_stall.
// ----------------------------------------------------------------------------
module gain_scheduled_pid_differential_drive (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  gspid_pkg::sample_t           sample,
    output logic                         result_valid,
    input  logic                         result_stall,
    output gspid_pkg::result_t           result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gspid_pkg::ADDR_W-1:0] paddr,
    input  logic [gspid_pkg::DATA_W-1:0] pwdata,
    output logic [gspid_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import gspid_pkg::*;
    `include "assert_macros.svh"

    cfg_t               cfg;
    stage_t             stage_reg;
    stage_t             stage_next;
    logic               stage_valid_reg;
    logic signed [15:0] integ_reg;
    logic signed [15:0] integ_next;
    logic signed [16:0] integ_sum;
    result_t            result_reg;
    result_t            result_next;
    logic               result_valid_reg;
    logic               accept;
    logic               advance;
    logic [7:0]         mag;
    logic signed [7:0]  e;
    logic signed [7:0]  p;

    gspid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gspid_core u_core (
        .stage  (stage_reg),
        .integ  (integ_reg),
        .cfg    (cfg),
        .result (result_next)
    );

    assign advance      = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = stage_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign e   = sample.error_now;
    assign p   = sample.error_before;
    assign mag = e[7] ? 8'(-e) : 8'(e);

    always_comb
    begin
        integ_sum = 17'(integ_reg) + 17'(e);
        if (e == 8'sd0)
            integ_next = 16'sd0;
        else if (e == p)
            integ_next = integ_reg;
        else if (integ_sum[16] != integ_sum[15])
            integ_next = integ_sum[16] ? 16'sh8000 : 16'sh7FFF;
        else
            integ_next = integ_sum[15:0];
    end

    always_comb
    begin
        stage_next.err    = e;
        stage_next.diff   = 9'(e) - 9'(p);
        stage_next.use_ki = 1'b0;
        if (mag == 8'(LEVEL_MIN))
            stage_next.sel = SEL_MIN;
        else if (mag == 8'(LEVEL_MEDIUM))
        begin
            stage_next.sel    = SEL_MEDIUM;
            stage_next.use_ki = 1'b1;
        end
        else if (mag == 8'(LEVEL_LARGE))
        begin
            stage_next.sel    = SEL_LARGE;
            stage_next.use_ki = 1'b1;
        end
        else if (mag == 8'(LEVEL_MAX))
        begin
            stage_next.sel    = SEL_MAX;
            stage_next.use_ki = 1'b1;
        end
        else if (mag == 8'(LEVEL_URGENT))
        begin
            stage_next.sel  = SEL_URGENT;
            stage_next.diff = 9'sd0;
        end
        else
            stage_next.sel = SEL_DEFAULT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            integ_reg        <= 16'sd0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
                integ_reg       <= integ_next;
            end
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= stage_next;
        if (advance)
            result_reg <= result_next;
    end

    `ASSERT_ALWAYS(a_stall_cause, !sample_stall || (stage_valid_reg && result_valid_reg && result_stall), "sample_stall without a stalled result")
    `ASSERT_NEXT(a_integ_clear, accept && (sample.error_now == 8'sd0), integ_reg == 16'sd0, "integrator not cleared on zero error")
    `ASSERT_ALWAYS(a_reverse_excl, !result_valid_reg || !(result_reg.left_reverse && result_reg.right_reverse), "both motors reversed")

endmodule

### design/gspid_regs.sv
// ----------------------------------------------------------------------------
// gspid_regs
// Configuration register file behind the APB port: gain sets, ki and limit.
// ----------------------------------------------------------------------------
module gspid_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gspid_pkg::ADDR_W-1:0] paddr,
    input  logic [gspid_pkg::DATA_W-1:0] pwdata,
    output logic [gspid_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output gspid_pkg::cfg_t            cfg
);
    import gspid_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gains <= '0;
            cfg_reg.ki    <= '0;
            cfg_reg.limit <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_INTEGRAL_GAIN: cfg_reg.ki    <= pwdata[15:0];
                REG_OUTPUT_LIMIT:  cfg_reg.limit <= pwdata[LIMIT_W-1:0];
                default:           cfg_reg.gains[idx] <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_INTEGRAL_GAIN: prdata = {16'd0, cfg_reg.ki};
            REG_OUTPUT_LIMIT:  prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_reg.limit};
            default:           prdata = cfg_reg.gains[idx];
        endcase
    end

endmodule

### design/gspid_core.sv
// ----------------------------------------------------------------------------
// gspid_core
// PID sum, output clamp and left/right speed forming for one staged sample.
// ----------------------------------------------------------------------------
module gspid_core (
    input  gspid_pkg::stage_t   stage,
    input  logic signed [15:0]  integ,
    input  gspid_pkg::cfg_t     cfg,
    output gspid_pkg::result_t  result
);
    import gspid_pkg::*;

    logic [31:0]        gain_word;
    logic signed [15:0] kp;
    logic signed [15:0] kd;
    logic signed [15:0] ki;
    logic signed [23:0] prod_p;
    logic signed [24:0] prod_d;
    logic signed [31:0] prod_i;
    logic signed [33:0] sum;
    logic signed [33:0] lim;
    logic signed [33:0] clamped;
    logic signed [14:0] pid;
    logic signed [15:0] left_val;
    logic signed [15:0] right_val;
    logic [14:0]        left_abs;
    logic [14:0]        right_abs;
    logic [14:0]        lim15;

    always_comb
    begin
        case (stage.sel)
            SEL_MIN:    gain_word = cfg.gains[SEL_MIN];
            SEL_MEDIUM: gain_word = cfg.gains[SEL_MEDIUM];
            SEL_LARGE:  gain_word = cfg.gains[SEL_LARGE];
            SEL_MAX:    gain_word = cfg.gains[SEL_MAX];
            SEL_URGENT: gain_word = cfg.gains[SEL_URGENT];
            default:    gain_word = cfg.gains[SEL_DEFAULT];
        endcase
    end

    assign kp = gain_word[31:16];
    assign kd = gain_word[15:0];
    assign ki = stage.use_ki ? cfg.ki : 16'sd0;

    assign prod_p = kp * stage.err;
    assign prod_d = kd * stage.diff;
    assign prod_i = ki * integ;
    assign sum    = 34'(prod_p) + 34'(prod_d) + 34'(prod_i);
    assign lim    = {{(34-LIMIT_W){1'b0}}, cfg.limit};

    always_comb
    begin
        if (sum <= -lim)
            clamped = -lim;
        else if (sum >= lim)
            clamped = lim;
        else
            clamped = sum;
    end

    assign pid       = clamped[14:0];
    assign left_val  = 16'(ONE_Q12) - 16'(pid);
    assign right_val = 16'(ONE_Q12) + 16'(pid);
    assign left_abs  = left_val[15]  ? 15'(-left_val)  : left_val[14:0];
    assign right_abs = right_val[15] ? 15'(-right_val) : right_val[14:0];
    assign lim15     = {1'b0, cfg.limit};

    assign result.pid_value     = pid;
    assign result.left_speed    = (left_abs >= lim15)  ? cfg.limit : left_abs[LIMIT_W-1:0];
    assign result.right_speed   = (right_abs >= lim15) ? cfg.limit : right_abs[LIMIT_W-1:0];
    assign result.left_reverse  = left_val[15];
    assign result.right_reverse = right_val[15];

endmodule
